[hw/rtl/utf8d_pkg.sv]
// types and constants shared by the terminal key utf-8 decoder
// no dependencies; used by utf8d_decode and terminal_key_utf8_decoder_top
`default_nettype none

package utf8d_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned KindW  = 4;
  localparam int unsigned CodeW  = 21;
  localparam int unsigned CountW = 3;

  typedef enum logic [KindW-1:0] {
    KIND_UNKNOWN   = 4'd0,
    KIND_CHAR      = 4'd1,
    KIND_TAB       = 4'd2,
    KIND_ENTER     = 4'd3,
    KIND_INS_NL    = 4'd4,
    KIND_CTRL_A    = 4'd5,
    KIND_CTRL_C    = 4'd6,
    KIND_CTRL_E    = 4'd7,
    KIND_CTRL_K    = 4'd8,
    KIND_CTRL_N    = 4'd9,
    KIND_CTRL_P    = 4'd10,
    KIND_CTRL_U    = 4'd11,
    KIND_CTRL_W    = 4'd12,
    KIND_BACKSPACE = 4'd13,
    KIND_ESC       = 4'd14
  } action_kind_e;

  // input byte codes
  localparam logic [ByteW-1:0] ByteTab    = 8'h09;
  localparam logic [ByteW-1:0] ByteLf     = 8'h0A;
  localparam logic [ByteW-1:0] ByteCr     = 8'h0D;
  localparam logic [ByteW-1:0] ByteCtrlA  = 8'h01;
  localparam logic [ByteW-1:0] ByteCtrlC  = 8'h03;
  localparam logic [ByteW-1:0] ByteCtrlE  = 8'h05;
  localparam logic [ByteW-1:0] ByteCtrlK  = 8'h0B;
  localparam logic [ByteW-1:0] ByteCtrlN  = 8'h0E;
  localparam logic [ByteW-1:0] ByteCtrlP  = 8'h10;
  localparam logic [ByteW-1:0] ByteCtrlU  = 8'h15;
  localparam logic [ByteW-1:0] ByteCtrlW  = 8'h17;
  localparam logic [ByteW-1:0] ByteEsc    = 8'h1B;
  localparam logic [ByteW-1:0] ByteDel    = 8'h7F;

  // code point limits
  localparam logic [CodeW-1:0] CpReplace   = 21'h00FFFD;
  localparam logic [CodeW-1:0] CpMax       = 21'h10FFFF;
  localparam logic [CodeW-1:0] CpSurrLo    = 21'h00D800;
  localparam logic [CodeW-1:0] CpSurrHi    = 21'h00DFFF;
  localparam logic [CodeW-1:0] CpFloor2    = 21'h000080;
  localparam logic [CodeW-1:0] CpFloor3    = 21'h000800;
  localparam logic [CodeW-1:0] CpFloor4    = 21'h010000;

  // sequence lengths
  localparam logic [CountW-1:0] Len2 = 3'd2;
  localparam logic [CountW-1:0] Len3 = 3'd3;
  localparam logic [CountW-1:0] Len4 = 3'd4;

  typedef struct packed {
    action_kind_e           kind;
    logic [CodeW-1:0]       code_point;
  } utf8d_result_t;

endpackage

`default_nettype wire

[hw/rtl/terminal_key_utf8_decoder_top.sv]
// top level of the terminal key decoder: input register, decode, result register
// depends on utf8d_pkg and utf8d_decode
//
// usage
// - slave channel s_axis_*: one raw terminal byte per beat in s_axis_tdata
// - master channel m_axis_*: one action per input byte; the action kind in
//   m_axis_tuser and the unicode code point in m_axis_tdata (zero unless
//   the kind is char)
// - path: an accepted byte is held in the input register, decoded, and its
//   action is captured in the result register, which drives the master beat
// - throughput: one byte per cycle sustained while m_axis_tready stays high; the byte
//   decode and sequence state update are combinational between the registers
// - lead bytes and inner continuation bytes give unknown; the final byte of
//   a utf-8 sequence gives char, with U+FFFD for overlong, surrogate or
//   out of range values; a non-continuation inside a sequence aborts it
// - reset: both registers empty, no sequence open, s_axis_tready high
// - stall: when m_axis_tready is low the result register holds, an empty
//   input register still takes one more byte, then s_axis_tready drops
//   until the result is taken; nothing is lost or repeated
`default_nettype none

module terminal_key_utf8_decoder_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // slave side
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  // master side
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,   // [20:0] code_point, [23:21] zero
  output logic [3:0]       m_axis_tuser    // [3:0] action_kind
);

  // input register
  logic                          in_valid_q, in_valid_d;
  logic [utf8d_pkg::ByteW-1:0]   in_byte_q;

  // result register
  logic                          out_valid_q, out_valid_d;
  utf8d_pkg::utf8d_result_t      out_res_q;

  utf8d_pkg::utf8d_result_t      dec_res;
  logic                          step;
  logic                          in_take;

  // the held byte moves on whenever the result register is free or draining
  assign step    = in_valid_q && (!out_valid_q || m_axis_tready);
  assign in_take = s_axis_tvalid && s_axis_tready;

  assign s_axis_tready = !in_valid_q || step;

  assign in_valid_d  = in_take || (in_valid_q && !step);
  assign out_valid_d = step || (out_valid_q && !m_axis_tready);

  utf8d_decode u_decode (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .byte_i   (in_byte_q),
    .result_o (dec_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q <= s_axis_tdata;
    end
    if (step) begin
      out_res_q <= dec_res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'd0, out_res_q.code_point};
  assign m_axis_tuser  = out_res_q.kind;

endmodule

`default_nettype wire

[hw/rtl/utf8d_decode.sv]
// byte classifier and utf-8 sequence decoder with its sequence state
// depends on utf8d_pkg
`default_nettype none

module utf8d_decode (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         step_i,
  input  wire logic [utf8d_pkg::ByteW-1:0]  byte_i,
  output utf8d_pkg::utf8d_result_t          result_o
);

  logic                          in_seq_q, in_seq_d;
  logic [utf8d_pkg::CountW-1:0]  held_q, held_d;
  logic [utf8d_pkg::CountW-1:0]  expected_q, expected_d;
  // first three bytes of the open sequence; the last byte is used directly
  logic [utf8d_pkg::ByteW-1:0]   seq_q [3];

  logic                          is_cont;
  logic [utf8d_pkg::CountW-1:0]  held_inc;
  logic                          last_byte;
  logic                          store_en;
  logic [1:0]                    store_idx;
  logic [utf8d_pkg::CodeW-1:0]   cp_raw;
  logic [utf8d_pkg::CodeW-1:0]   cp_floor;
  logic [utf8d_pkg::CodeW-1:0]   cp_seq;

  assign is_cont   = (byte_i[7:6] == 2'b10);
  assign held_inc  = held_q + 3'd1;
  assign last_byte = (held_inc >= expected_q);

  // assemble the code point from the held bytes plus the current byte
  always_comb begin
    case (expected_q)
      utf8d_pkg::Len2: begin
        cp_raw   = {10'd0, seq_q[0][4:0], byte_i[5:0]};
        cp_floor = utf8d_pkg::CpFloor2;
      end
      utf8d_pkg::Len3: begin
        cp_raw   = {5'd0, seq_q[0][3:0], seq_q[1][5:0], byte_i[5:0]};
        cp_floor = utf8d_pkg::CpFloor3;
      end
      default: begin
        cp_raw   = {seq_q[0][2:0], seq_q[1][5:0], seq_q[2][5:0], byte_i[5:0]};
        cp_floor = utf8d_pkg::CpFloor4;
      end
    endcase
  end

  // overlong, surrogate and out of range all become the replacement char
  always_comb begin
    if ((cp_raw < cp_floor) || (cp_raw > utf8d_pkg::CpMax) ||
        ((cp_raw >= utf8d_pkg::CpSurrLo) && (cp_raw <= utf8d_pkg::CpSurrHi))) begin
      cp_seq = utf8d_pkg::CpReplace;
    end else begin
      cp_seq = cp_raw;
    end
  end

  // result and next state
  always_comb begin
    in_seq_d            = in_seq_q;
    held_d              = held_q;
    expected_d          = expected_q;
    store_en            = 1'b0;
    store_idx           = held_q[1:0];
    result_o.kind       = utf8d_pkg::KIND_UNKNOWN;
    result_o.code_point = '0;
    if (in_seq_q) begin
      if (!is_cont) begin
        in_seq_d   = 1'b0;
        held_d     = '0;
        expected_d = '0;
      end else if (last_byte) begin
        result_o.kind       = utf8d_pkg::KIND_CHAR;
        result_o.code_point = cp_seq;
        in_seq_d            = 1'b0;
        held_d              = '0;
        expected_d          = '0;
      end else begin
        store_en = 1'b1;
        held_d   = held_inc;
      end
    end else begin
      case (byte_i)
        utf8d_pkg::ByteEsc:   result_o.kind = utf8d_pkg::KIND_ESC;
        utf8d_pkg::ByteTab:   result_o.kind = utf8d_pkg::KIND_TAB;
        utf8d_pkg::ByteCr:    result_o.kind = utf8d_pkg::KIND_ENTER;
        utf8d_pkg::ByteLf:    result_o.kind = utf8d_pkg::KIND_INS_NL;
        utf8d_pkg::ByteCtrlA: result_o.kind = utf8d_pkg::KIND_CTRL_A;
        utf8d_pkg::ByteCtrlC: result_o.kind = utf8d_pkg::KIND_CTRL_C;
        utf8d_pkg::ByteCtrlE: result_o.kind = utf8d_pkg::KIND_CTRL_E;
        utf8d_pkg::ByteCtrlK: result_o.kind = utf8d_pkg::KIND_CTRL_K;
        utf8d_pkg::ByteCtrlN: result_o.kind = utf8d_pkg::KIND_CTRL_N;
        utf8d_pkg::ByteCtrlP: result_o.kind = utf8d_pkg::KIND_CTRL_P;
        utf8d_pkg::ByteCtrlU: result_o.kind = utf8d_pkg::KIND_CTRL_U;
        utf8d_pkg::ByteCtrlW: result_o.kind = utf8d_pkg::KIND_CTRL_W;
        utf8d_pkg::ByteDel:   result_o.kind = utf8d_pkg::KIND_BACKSPACE;
        default: begin
          if (byte_i inside {[8'h20:8'h7E]}) begin
            result_o.kind       = utf8d_pkg::KIND_CHAR;
            result_o.code_point = {13'd0, byte_i};
          end else if (byte_i inside {[8'hC0:8'hDF]}) begin
            in_seq_d   = 1'b1;
            held_d     = 3'd1;
            expected_d = utf8d_pkg::Len2;
            store_en   = 1'b1;
            store_idx  = 2'd0;
          end else if (byte_i inside {[8'hE0:8'hEF]}) begin
            in_seq_d   = 1'b1;
            held_d     = 3'd1;
            expected_d = utf8d_pkg::Len3;
            store_en   = 1'b1;
            store_idx  = 2'd0;
          end else if (byte_i inside {[8'hF0:8'hF7]}) begin
            in_seq_d   = 1'b1;
            held_d     = 3'd1;
            expected_d = utf8d_pkg::Len4;
            store_en   = 1'b1;
            store_idx  = 2'd0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_seq_q   <= 1'b0;
      held_q     <= '0;
      expected_q <= '0;
    end else if (step_i) begin
      in_seq_q   <= in_seq_d;
      held_q     <= held_d;
      expected_q <= expected_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i && store_en) begin
      seq_q[store_idx] <= byte_i;
    end
  end

  // closed sequence leaves no count behind
  a_idle_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_seq_q |-> (held_q == 3'd0) && (expected_q == 3'd0))
    else $error("sequence counters not cleared while idle");

  // an open sequence always has at least one byte still to come
  a_open_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_seq_q |-> (held_q >= 3'd1) && (held_q < expected_q) &&
                 ((expected_q == utf8d_pkg::Len2) || (expected_q == utf8d_pkg::Len3) ||
                  (expected_q == utf8d_pkg::Len4)))
    else $error("open sequence has inconsistent counts");

  // decoded characters are always valid scalar values
  a_cp_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_seq_q && result_o.kind == utf8d_pkg::KIND_CHAR) |->
      (result_o.code_point <= utf8d_pkg::CpMax) &&
      !((result_o.code_point >= utf8d_pkg::CpSurrLo) &&
        (result_o.code_point <= utf8d_pkg::CpSurrHi)))
    else $error("decoded code point not a valid scalar value");

  // a step that finishes a sequence returns to idle
  a_char_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && in_seq_q && result_o.kind == utf8d_pkg::KIND_CHAR) |=> !in_seq_q)
    else $error("sequence still open after its last byte");

endmodule

`default_nettype wire

[tb/terminal_key_utf8_decoder_top_test.sv]
// self-checking testbench for terminal_key_utf8_decoder_top: raw terminal bytes in, actions out
// depends on utf8d_pkg and the decoder rtl; its own byte decoder predicts untyped actions
module terminal_key_utf8_decoder_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit  = 300000;  // far above the slowest legal run
  localparam int unsigned RandomBytes = 800;
  localparam int unsigned SettleCycles = 8;      // result path is two registers deep
  localparam logic [utf8d_pkg::ByteW-1:0] BytePrintLo = 8'h20;

  // one row of the directed table; typed rows carry their action, the rest use the predictor
  typedef struct {
    logic [utf8d_pkg::ByteW-1:0] in_byte;
    bit                          typed;
    utf8d_pkg::action_kind_e     kind;
    logic [utf8d_pkg::CodeW-1:0] code_point;
  } key_row_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [7:0]       s_axis_tdata = 8'h00;   // [7:0] in_byte
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [23:0]      m_axis_tdata;           // [20:0] code_point, [23:21] zero
  logic [3:0]       m_axis_tuser;           // [3:0] action_kind

  // predictor state: mirrors the open utf-8 sequence
  logic                             seq_open = 1'b0;
  logic [utf8d_pkg::CountW-1:0]     seq_held = '0;
  logic [utf8d_pkg::CountW-1:0]     seq_need = '0;
  logic [utf8d_pkg::ByteW-1:0]      seq_bytes [4];

  utf8d_pkg::utf8d_result_t    pending_actions [$];
  utf8d_pkg::utf8d_result_t    oldest_action;
  int unsigned      errors = 0;
  int unsigned      bytes_sent = 0;
  int unsigned      actions_checked = 0;
  int unsigned      seq_chars = 0;
  int unsigned      replaced_chars = 0;
  bit               src_calm = 1'b0;
  bit               sink_calm = 1'b0;
  int unsigned      sink_hold = 0;
  int unsigned      sink_mode_left = 0;

  // directed table: extremes, every key, each replacement reason and an aborted sequence
  key_row_t key_rows [27] = '{
    '{8'h00,                1'b1, utf8d_pkg::KIND_UNKNOWN,   21'h0},  // lowest byte
    '{8'hFF,                1'b1, utf8d_pkg::KIND_UNKNOWN,   21'h0},  // highest, never a lead
    '{utf8d_pkg::ByteTab,   1'b1, utf8d_pkg::KIND_TAB,       21'h0},
    '{utf8d_pkg::ByteCr,    1'b1, utf8d_pkg::KIND_ENTER,     21'h0},
    '{utf8d_pkg::ByteLf,    1'b1, utf8d_pkg::KIND_INS_NL,    21'h0},
    '{utf8d_pkg::ByteCtrlA, 1'b1, utf8d_pkg::KIND_CTRL_A,    21'h0},
    '{utf8d_pkg::ByteCtrlC, 1'b1, utf8d_pkg::KIND_CTRL_C,    21'h0},
    '{utf8d_pkg::ByteCtrlE, 1'b1, utf8d_pkg::KIND_CTRL_E,    21'h0},
    '{utf8d_pkg::ByteCtrlK, 1'b1, utf8d_pkg::KIND_CTRL_K,    21'h0},
    '{utf8d_pkg::ByteCtrlN, 1'b1, utf8d_pkg::KIND_CTRL_N,    21'h0},
    '{utf8d_pkg::ByteCtrlP, 1'b1, utf8d_pkg::KIND_CTRL_P,    21'h0},
    '{utf8d_pkg::ByteCtrlU, 1'b1, utf8d_pkg::KIND_CTRL_U,    21'h0},
    '{utf8d_pkg::ByteCtrlW, 1'b1, utf8d_pkg::KIND_CTRL_W,    21'h0},
    '{utf8d_pkg::ByteDel,   1'b1, utf8d_pkg::KIND_BACKSPACE, 21'h0},
    '{utf8d_pkg::ByteEsc,   1'b1, utf8d_pkg::KIND_ESC,       21'h0},
    '{8'h7E,                1'b0, utf8d_pkg::KIND_UNKNOWN,   21'h0},  // top printable
    '{8'hC0,                1'b1, utf8d_pkg::KIND_UNKNOWN,   21'h0},  // overlong two-byte form
    '{8'h80,                1'b1, utf8d_pkg::KIND_CHAR,      utf8d_pkg::CpReplace},
    '{8'hED,                1'b1, utf8d_pkg::KIND_UNKNOWN,   21'h0},  // encodes a surrogate
    '{8'hA0,                1'b1, utf8d_pkg::KIND_UNKNOWN,   21'h0},
    '{8'h80,                1'b1, utf8d_pkg::KIND_CHAR,      utf8d_pkg::CpReplace},
    '{8'hF7,                1'b1, utf8d_pkg::KIND_UNKNOWN,   21'h0},  // far above unicode
    '{8'hBF,                1'b1, utf8d_pkg::KIND_UNKNOWN,   21'h0},
    '{8'hBF,                1'b1, utf8d_pkg::KIND_UNKNOWN,   21'h0},
    '{8'hBF,                1'b1, utf8d_pkg::KIND_CHAR,      utf8d_pkg::CpReplace},
    '{8'hE2,                1'b1, utf8d_pkg::KIND_UNKNOWN,   21'h0},  // sequence cut short ...
    '{utf8d_pkg::ByteEsc,   1'b1, utf8d_pkg::KIND_UNKNOWN,   21'h0}   // ... so esc is swallowed
  };

  logic [utf8d_pkg::ByteW-1:0] key_bytes [13] = '{
    utf8d_pkg::ByteTab, utf8d_pkg::ByteCr, utf8d_pkg::ByteLf, utf8d_pkg::ByteCtrlA,
    utf8d_pkg::ByteCtrlC, utf8d_pkg::ByteCtrlE, utf8d_pkg::ByteCtrlK, utf8d_pkg::ByteCtrlN,
    utf8d_pkg::ByteCtrlP, utf8d_pkg::ByteCtrlU, utf8d_pkg::ByteCtrlW, utf8d_pkg::ByteDel,
    utf8d_pkg::ByteEsc
  };

  // leads that sit on the overlong, surrogate and range boundaries
  logic [utf8d_pkg::ByteW-1:0] boundary_leads [11] = '{
    8'hC0, 8'hC1, 8'hC2, 8'hDF, 8'hE0, 8'hED, 8'hEF, 8'hF0, 8'hF4, 8'hF5, 8'hF7
  };

  terminal_key_utf8_decoder_top dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tuser
  );

  always #5 clk_i = ~clk_i;

  // predicts the action for one accepted byte and advances the sequence state
  function automatic utf8d_pkg::utf8d_result_t decode_key_byte(
      input logic [utf8d_pkg::ByteW-1:0] b);
    utf8d_pkg::utf8d_result_t    act;
    logic [utf8d_pkg::CodeW-1:0] cp;
    logic [utf8d_pkg::CodeW-1:0] lowest;
    act.kind       = utf8d_pkg::KIND_UNKNOWN;
    act.code_point = '0;
    if (seq_open) begin
      if (b[7:6] != 2'b10) begin
        // not a continuation: the sequence is dropped and the byte eaten
        seq_open = 1'b0;
        seq_held = '0;
        seq_need = '0;
      end else begin
        seq_bytes[seq_held[1:0]] = b;
        seq_held = seq_held + 1'b1;
        if (seq_held >= seq_need) begin
          case (seq_need)
            utf8d_pkg::Len2: begin
              cp     = {10'd0, seq_bytes[0][4:0], seq_bytes[1][5:0]};
              lowest = utf8d_pkg::CpFloor2;
            end
            utf8d_pkg::Len3: begin
              cp     = {5'd0, seq_bytes[0][3:0], seq_bytes[1][5:0], seq_bytes[2][5:0]};
              lowest = utf8d_pkg::CpFloor3;
            end
            default: begin
              cp     = {seq_bytes[0][2:0], seq_bytes[1][5:0], seq_bytes[2][5:0],
                        seq_bytes[3][5:0]};
              lowest = utf8d_pkg::CpFloor4;
            end
          endcase
          seq_chars++;
          if (cp < lowest || cp > utf8d_pkg::CpMax ||
              (cp >= utf8d_pkg::CpSurrLo && cp <= utf8d_pkg::CpSurrHi)) begin
            cp = utf8d_pkg::CpReplace;
            replaced_chars++;
          end
          act.kind       = utf8d_pkg::KIND_CHAR;
          act.code_point = cp;
          seq_open = 1'b0;
          seq_held = '0;
          seq_need = '0;
        end
      end
    end else begin
      case (b)
        utf8d_pkg::ByteEsc:   act.kind = utf8d_pkg::KIND_ESC;
        utf8d_pkg::ByteTab:   act.kind = utf8d_pkg::KIND_TAB;
        utf8d_pkg::ByteCr:    act.kind = utf8d_pkg::KIND_ENTER;
        utf8d_pkg::ByteLf:    act.kind = utf8d_pkg::KIND_INS_NL;
        utf8d_pkg::ByteCtrlA: act.kind = utf8d_pkg::KIND_CTRL_A;
        utf8d_pkg::ByteCtrlC: act.kind = utf8d_pkg::KIND_CTRL_C;
        utf8d_pkg::ByteCtrlE: act.kind = utf8d_pkg::KIND_CTRL_E;
        utf8d_pkg::ByteCtrlK: act.kind = utf8d_pkg::KIND_CTRL_K;
        utf8d_pkg::ByteCtrlN: act.kind = utf8d_pkg::KIND_CTRL_N;
        utf8d_pkg::ByteCtrlP: act.kind = utf8d_pkg::KIND_CTRL_P;
        utf8d_pkg::ByteCtrlU: act.kind = utf8d_pkg::KIND_CTRL_U;
        utf8d_pkg::ByteCtrlW: act.kind = utf8d_pkg::KIND_CTRL_W;
        utf8d_pkg::ByteDel:   act.kind = utf8d_pkg::KIND_BACKSPACE;
        default: begin
          if (b >= BytePrintLo && b < utf8d_pkg::ByteDel) begin
            act.kind       = utf8d_pkg::KIND_CHAR;
            act.code_point = {13'd0, b};
          end else if (b[7:5] == 3'b110 || b[7:4] == 4'b1110 || b[7:3] == 5'b11110) begin
            // lead byte: remember it, answer unknown for now
            seq_open     = 1'b1;
            seq_held     = 3'd1;
            seq_bytes[0] = b;
            if (b[7:5] == 3'b110) seq_need = utf8d_pkg::Len2;
            else if (b[7:4] == 4'b1110) seq_need = utf8d_pkg::Len3;
            else seq_need = utf8d_pkg::Len4;
          end
          // stray continuations and 0xf8..0xff fall through as unknown
        end
      endcase
    end
    return act;
  endfunction

  // mostly back to back, now and then a short gap, rarely a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [utf8d_pkg::ByteW-1:0] pick_lead();
    logic [utf8d_pkg::ByteW-1:0] b;
    b = 8'($urandom);
    if ($urandom_range(0, 3) == 0) return boundary_leads[$urandom_range(0, 10)];
    case ($urandom_range(2, 4))
      2:       return {3'b110, b[4:0]};
      3:       return {4'b1110, b[3:0]};
      default: return {5'b11110, b[2:0]};
    endcase
  endfunction

  // drives one beat at the falling edge, holds it until taken, then records its action
  task automatic send_byte(input logic [utf8d_pkg::ByteW-1:0] b, input bit typed,
                           input utf8d_pkg::utf8d_result_t typed_action);
    int unsigned gap;
    utf8d_pkg::utf8d_result_t predicted;
    gap = src_calm ? 0 : pick_gap();
    if (gap != 0) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = decode_key_byte(b);
    pending_actions.push_back(typed ? typed_action : predicted);
    bytes_sent++;
  endtask

  task automatic send_cont();
    logic [utf8d_pkg::ByteW-1:0] b;
    b = 8'($urandom);
    send_byte({2'b10, b[5:0]}, 1'b0, '0);
  endtask

  // stop sending and let every outstanding action come back
  task automatic wait_for_actions();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_actions.size() != 0) @(posedge clk_i);
  endtask

  // sink side: ready changes at the falling edge, with calm and stalling stretches
  always @(negedge clk_i) begin
    if (sink_mode_left == 0) begin
      sink_calm      = ($urandom_range(0, 2) == 0);
      sink_mode_left = $urandom_range(50, 300);
    end
    sink_mode_left--;
    if (sink_hold != 0) begin
      m_axis_tready <= 1'b0;
      sink_hold--;
    end else begin
      m_axis_tready <= 1'b1;
      if (!sink_calm) sink_hold = pick_gap();
    end
  end

  // every beat on the master side is matched against the oldest expected action
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_actions.size() == 0) begin
        $error("unexpected action: kind %0d code_point 0x%0h", m_axis_tuser, m_axis_tdata);
        errors++;
      end else begin
        oldest_action = pending_actions.pop_front();
        if (m_axis_tuser !== oldest_action.kind) begin
          $error("action_kind: expected %0d, got %0d", oldest_action.kind, m_axis_tuser);
          errors++;
        end
        if (m_axis_tdata !== {3'b000, oldest_action.code_point}) begin
          $error("code_point: expected 0x%0h, got 0x%0h",
                 {3'b000, oldest_action.code_point}, m_axis_tdata);
          errors++;
        end
        actions_checked++;
      end
    end
  end

  // watchdog
  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("cycle limit reached with %0d actions outstanding", pending_actions.size());
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    int unsigned pick;
    int unsigned len;
    int unsigned next_mode_change;
    int unsigned next_drain;
    logic [utf8d_pkg::ByteW-1:0] lead;
    logic [utf8d_pkg::ByteW-1:0] b;

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed part, with random gaps already in play
    foreach (key_rows[i]) begin
      send_byte(key_rows[i].in_byte, key_rows[i].typed,
                utf8d_pkg::utf8d_result_t'({key_rows[i].kind, key_rows[i].code_point}));
    end
    // sender holds off until the decoder is empty
    wait_for_actions();

    next_mode_change = bytes_sent;
    next_drain       = bytes_sent + 250;
    while (bytes_sent < $size(key_rows) + RandomBytes) begin
      if (bytes_sent >= next_mode_change) begin
        src_calm         = ($urandom_range(0, 3) == 0);
        next_mode_change = bytes_sent + 100;
      end
      if (bytes_sent >= next_drain) begin
        wait_for_actions();
        next_drain = bytes_sent + 250;
      end
      pick = $urandom_range(0, 99);
      if (pick < 82 && pick >= 72) begin
        // broken sequence: lead, too few continuations, then a non-continuation
        lead = pick_lead();
        len  = (lead[7:5] == 3'b110) ? 2 : (lead[7:4] == 4'b1110) ? 3 : 4;
        send_byte(lead, 1'b0, '0);
        repeat ($urandom_range(0, len - 2)) send_cont();
        b = 8'($urandom);
        if (b[7:6] == 2'b10) b[6] = 1'b1;
        send_byte(b, 1'b0, '0);
      end else if (pick < 45) begin
        // complete sequence with random payload bits
        lead = pick_lead();
        len  = (lead[7:5] == 3'b110) ? 2 : (lead[7:4] == 4'b1110) ? 3 : 4;
        send_byte(lead, 1'b0, '0);
        repeat (len - 1) send_cont();
      end else if (pick < 60) begin
        send_byte(8'($urandom_range(BytePrintLo, utf8d_pkg::ByteDel - 1)), 1'b0, '0);
      end else if (pick < 72) begin
        send_byte(key_bytes[$urandom_range(0, 12)], 1'b0, '0);
      end else begin
        // any byte at all, stray continuations and 0xf8..0xff among them
        send_byte(8'($urandom), 1'b0, '0);
      end
    end

    wait_for_actions();
    repeat (SettleCycles) @(posedge clk_i);

    $display("%0d bytes sent, %0d actions checked", bytes_sent, actions_checked);
    $display("%0d multi-byte chars decoded, %0d of them replaced by U+FFFD",
             seq_chars, replaced_chars);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
